### rtl/stbs_pkg.sv
// shared types and constants for the sorted table search block
package stbs_pkg;

	localparam int CMD_W         = 2;
	localparam int VAL_W         = 32;
	localparam int POS_W         = 10;
	localparam int DEFAULT_DEPTH = 1024;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	// search result handed from the sequencer to the output register
	typedef struct packed {
		logic             valid;
		logic             found;
		logic [POS_W-1:0] position;
	} stbs_res_t;

endpackage

### rtl/stbs_ifs.sv
// valid/ready channel interfaces for commands and search results
interface stbs_cmd_if;
	import stbs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface stbs_res_if;
	import stbs_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source (output valid, output found, output position, input ready);
	modport sink   (input valid, input found, input position, output ready);
endinterface

### rtl/sorted_table_binary_search.sv
// Sorted table with binary search lookup: clear, append and search commands.
// Clear, append and unused commands leave the sequencer idle; the next command is accepted the cycle after.
// A search makes k probes (k <= ceil(log2(entries+1)), 11 for a full 1024-entry table); each probe
// is a read of the single element memory read port in ST_PROBE followed by a compare in ST_CMP.
// The result then waits in ST_DONE for the output register; no new command is accepted until then.
// Reset clears the entry count and the control state; table contents are undefined until appended.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	stbs_cmd_if.sink request,
	stbs_res_if.source response
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	// sequencer to output register
	stbs_res_t        res;
	logic             res_free;

	// element memory ports
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;

	// output register
	logic             out_valid_q;
	logic             out_found_q;
	logic [POS_W-1:0] out_pos_q;

	// the output register frees up in the same cycle that its transaction completes
	assign res_free = !out_valid_q || response.ready;

	stbs_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.res_free (res_free),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// one table of signed elements, registered read for the probe loop
	stbs_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.DW    (VAL_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result holding register decouples the search loop from a stalled consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_pos_q   <= '0;
		end else begin
			if (res.valid) begin
				out_valid_q <= 1'b1;
				out_found_q <= res.found;
				out_pos_q   <= res.position;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign response.valid    = out_valid_q;
	assign response.found    = out_found_q;
	assign response.position = out_pos_q;

endmodule

### rtl/stbs_mem.sv
// single-port-write, registered-read element memory
module stbs_mem #(
	parameter int DEPTH = stbs_pkg::DEFAULT_DEPTH,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = stbs_pkg::VAL_W
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/stbs_ctrl.sv
// command sequencer: entry count, appends and the binary search probe loop
module stbs_ctrl #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	stbs_cmd_if.sink                 request,
	input  logic                     res_free,
	output stbs_pkg::stbs_res_t      res,
	output logic                     wr_en,
	output logic [AW-1:0]            wr_addr,
	output logic [stbs_pkg::VAL_W-1:0] wr_data,
	output logic                     rd_en,
	output logic [AW-1:0]            rd_addr,
	input  logic [stbs_pkg::VAL_W-1:0] rd_data
);
	import stbs_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hi_q;     // exclusive upper bound
	logic [CW-1:0]           mid_q;
	logic signed [VAL_W-1:0] key_q;
	logic                    found_q;
	logic [POS_W-1:0]        pos_q;

	logic                    accept;
	logic                    full;
	logic                    range_open;
	logic [CW-1:0]           span;
	logic [CW-1:0]           mid_w;
	logic [CW+POS_W-1:0]     mid_wide;
	logic signed [VAL_W-1:0] probe;

	assign accept     = request.valid && request.ready;
	assign full       = (count_q == CW'(TABLE_DEPTH));
	assign range_open = (lo_q < hi_q);
	assign span       = hi_q - lo_q - CW'(1);
	assign mid_w      = lo_q + (span >> 1);
	assign mid_wide   = {{POS_W{1'b0}}, mid_q};
	assign probe      = $signed(rd_data);

	assign request.ready = (state_q == ST_IDLE);

	assign wr_en   = accept && (request.command == CMD_APPEND) && !full;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = request.value;

	assign rd_en   = (state_q == ST_PROBE) && range_open;
	assign rd_addr = mid_w[AW-1:0];

	assign res.valid    = (state_q == ST_DONE) && res_free;
	assign res.found    = found_q;
	assign res.position = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			key_q   <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (request.command)
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_APPEND: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_SEARCH: begin
								lo_q    <= '0;
								hi_q    <= count_q;
								key_q   <= request.value;
								found_q <= 1'b0;
								pos_q   <= '0;
								state_q <= ST_PROBE;
							end
							default: begin
								// unused code, dropped
							end
						endcase
					end
				end
				ST_PROBE: begin
					if (range_open) begin
						mid_q   <= mid_w;
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CMP: begin
					if (probe == key_q) begin
						found_q <= 1'b1;
						pos_q   <= mid_wide[POS_W-1:0];
						state_q <= ST_DONE;
					end else if (probe < key_q) begin
						lo_q    <= mid_q + CW'(1);
						state_q <= ST_PROBE;
					end else begin
						hi_q    <= mid_q;
						state_q <= ST_PROBE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && request.command == CMD_SEARCH |=> state_q == ST_PROBE)
		else $error("search accepted but probe loop not started");

	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res_free)
		else $error("result issued while output register occupied");

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> lo_q <= hi_q && hi_q <= count_q)
		else $error("search bounds out of order");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> mid_w < count_q)
		else $error("probe beyond filled entries");

endmodule

### tb/tb_sorted_table_binary_search.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted table binary search block
module tb_sorted_table_binary_search;
	import stbs_pkg::*;

	localparam int DEPTH          = DEFAULT_DEPTH;
	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction on either channel
	localparam int HOLD_CYCLES    = 400;    // long receiver hold-off in the pressure phase
	localparam int DRAIN_CYCLES   = 50;     // quiet time after the last result
	localparam int IDLE_PCT       = 16;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	// one expected lookup answer
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} lookup_t;

	// mirrors the table contents and holds the lookup answers still owed by the block
	class search_scoreboard;
		logic signed [VAL_W-1:0] entries [DEPTH];
		int      fill;
		lookup_t owed [$];
		int      errors;
		int      searches;
		int      hits;

		function new();
			fill     = 0;
			errors   = 0;
			searches = 0;
			hits     = 0;
		endfunction

		// same probe order as the block: inclusive range, mid rounds toward left
		function lookup_t bisect(logic signed [VAL_W-1:0] key);
			int      lo;
			int      hi;
			int      mid;
			lookup_t answer;
			answer = '0;
			lo     = 0;
			hi     = fill - 1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (entries[mid] == key) begin
					answer.found    = 1'b1;
					answer.position = POS_W'(mid);
					break;
				end else if (entries[mid] < key) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			return answer;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val);
			lookup_t answer;
			case (cmd)
				CMD_CLEAR: begin
					fill = 0;
				end
				CMD_APPEND: begin
					if (fill < DEPTH) begin
						entries[fill] = val;
						fill++;
					end
				end
				CMD_SEARCH: begin
					answer = bisect(val);
					searches++;
					if (answer.found)
						hits++;
					owed.push_back(answer);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic found, logic [POS_W-1:0] position);
			lookup_t want;
			if (owed.size() == 0) begin
				$display("%0t unexpected result: found=%0b position=%0d", $time, found, position);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (found !== want.found) begin
				$display("%0t found mismatch: expected %0b actual %0b", $time, want.found, found);
				errors++;
			end
			if (position !== want.position) begin
				$display("%0t position mismatch: expected %0d actual %0d",
					$time, want.position, position);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stbs_cmd_if req_ch();
	stbs_res_if res_ch();

	search_scoreboard sb = new();

	// shared control between stimulus, receiver and watchdog
	bit no_idle      = 1'b0;
	int hold_request = 0;
	int hold_left    = 0;
	int items_sent   = 0;
	int quiet_cycles = 0;

	sorted_table_binary_search dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.response(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// random value of a given flavor: 0 full range, 1 narrow range (duplicates), 2 mostly boundary values
	function automatic logic signed [VAL_W-1:0] rand_value(int flavor);
		logic signed [VAL_W-1:0] v;
		case (flavor)
			1: v = $signed($urandom_range(16)) - 8;
			2: begin
				case ($urandom_range(7))
					0: v = VAL_MIN;
					1: v = VAL_MIN + 1;
					2: v = -1;
					3: v = 0;
					4: v = 1;
					5: v = VAL_MAX - 1;
					6: v = VAL_MAX;
					default: v = $urandom;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// offer one transaction, with random idle cycles ahead of it, and wait for acceptance
	task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value   <= val;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_command(cmd, val);
		items_sent++;
	endtask

	// occasional junk between the well-formed transactions
	task automatic maybe_noise();
		if ($urandom_range(99) < 8)
			send_item(CMD_CLEAR + CMD_W'($urandom_range(3)), rand_value(0));
	endtask

	// drop valid and hold the sender until every owed result has come back
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
	endtask

	// clear, build a table of the given size, then look up a handful of keys
	task automatic table_sequence(int size, int flavor, bit sorted);
		int                      vals [0:255];
		int                      i;
		int                      j;
		int                      tmp;
		int                      lookups;
		logic signed [VAL_W-1:0] key;
		for (i = 0; i < size; i++)
			vals[i] = rand_value(flavor);
		if (sorted) begin
			for (i = 1; i < size; i++) begin
				tmp = vals[i];
				j   = i - 1;
				while (j >= 0 && vals[j] > tmp) begin
					vals[j + 1] = vals[j];
					j--;
				end
				vals[j + 1] = tmp;
			end
		end
		send_item(CMD_CLEAR, rand_value(0));
		for (i = 0; i < size; i++) begin
			send_item(CMD_APPEND, vals[i]);
			maybe_noise();
		end
		lookups = $urandom_range(10, 3);
		for (i = 0; i < lookups; i++) begin
			tmp = $urandom_range(99);
			if (size > 0 && tmp < 55)
				key = vals[$urandom_range(size - 1)];
			else if (size > 0 && tmp < 75)
				key = vals[$urandom_range(size - 1)] + ($urandom_range(1) ? 1 : -1);
			else
				key = rand_value(flavor);
			send_item(CMD_SEARCH, key);
			maybe_noise();
		end
	endtask

	task automatic random_sequences(int until_count);
		int size;
		int flavor;
		while (items_sent < until_count) begin
			size   = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(24);
			flavor = $urandom_range(2);
			table_sequence(size, flavor, $urandom_range(99) >= 15);
		end
	endtask

	// receiver: random ready, plus a long hold-off on request, counted here
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.found, res_ch.position);
		end
	end

	// watchdog: end the run if the channels go quiet for too long
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t watchdog: no transaction for %0d cycles, %0d results owed",
			$time, WATCHDOG_LIMIT, sb.owed.size());
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin
		int i;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.command = CMD_CLEAR;
		req_ch.value   = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, unused command, extreme values, duplicates, unsorted
		send_item(CMD_SEARCH, 0);
		send_item(CMD_UNUSED, $urandom);
		send_item(CMD_SEARCH, 5);
		send_item(CMD_APPEND, VAL_MIN);
		send_item(CMD_APPEND, -1);
		send_item(CMD_APPEND, 0);
		send_item(CMD_APPEND, 1);
		send_item(CMD_APPEND, VAL_MAX);
		send_item(CMD_SEARCH, VAL_MIN);
		send_item(CMD_SEARCH, VAL_MAX);
		send_item(CMD_SEARCH, 0);
		send_item(CMD_SEARCH, -1);
		send_item(CMD_SEARCH, 5);
		send_item(CMD_SEARCH, VAL_MIN + 1);
		send_item(CMD_CLEAR, $urandom);
		send_item(CMD_APPEND, 7);
		send_item(CMD_APPEND, 7);
		send_item(CMD_APPEND, 7);
		send_item(CMD_SEARCH, 7);
		send_item(CMD_CLEAR, 0);
		send_item(CMD_APPEND, 30);
		send_item(CMD_APPEND, -4);
		send_item(CMD_APPEND, 12);
		send_item(CMD_SEARCH, -4);
		send_item(CMD_SEARCH, 30);
		send_item(CMD_CLEAR, 0);
		send_item(CMD_SEARCH, 0);
		drain();

		// random tables and lookups with idling on both sides
		random_sequences(items_sent + 300);

		// back-pressure: receiver holds off while searches keep coming
		table_sequence(16, 0, 1'b1);
		hold_request = HOLD_CYCLES;
		for (i = 0; i < 30; i++)
			send_item(CMD_SEARCH, rand_value(2));
		drain();

		// stretch with no idling at all
		no_idle = 1'b1;
		random_sequences(items_sent + 150);
		drain();
		no_idle = 1'b0;

		random_sequences(items_sent + 150);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.owed.size() != 0) begin
			$display("%0t %0d results never arrived", $time, sb.owed.size());
			sb.errors++;
		end

		$display("run covered %0d transactions, %0d searches (%0d hits)",
			items_sent, sb.searches, sb.hits);
		$display("with empty, unsorted and duplicate tables, edge keys and a long receiver stall");
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
